>>> design/mwm_pkg.sv
// ---------------------------------------------------------------------------
// mwm_pkg: shared widths and types of the mecanum wheel mixer
// Field widths, internal arithmetic widths and the limit reset value.
// ---------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

  localparam int InW   = 16;  // body command fields
  localparam int OutW  = 16;  // wheel command fields
  localparam int SumW  = 18;  // signed wheel sum, three 16-bit terms
  localparam int MagW  = 17;  // magnitude of a wheel sum
  localparam int LimW  = 15;  // wheel limit register
  localparam int ProdW = MagW + LimW;  // magnitude times limit
  localparam int QuoW  = LimW;         // scaled magnitude never exceeds the limit
  localparam int NumWheels = 4;

  localparam logic [LimW-1:0] LimitReset = LimW'(7200);

  // wheel order: front left, front right, rear left, rear right
  typedef logic [NumWheels-1:0][MagW-1:0] wheel_mag_t;

  // per-item data that rides alongside the divider lanes
  typedef struct packed {
    wheel_mag_t           mag;
    logic [NumWheels-1:0] neg;
    logic                 scaled;
  } side_t;

endpackage

`default_nettype wire

>>> design/mwm_div_pipe.sv
// ---------------------------------------------------------------------------
// mwm_div_pipe: pipelined restoring divider lane
// One quotient bit per register stage, most significant bit first.
// The quotient is exact when it fits in QuoW bits.
// ---------------------------------------------------------------------------
`default_nettype none

module mwm_div_pipe (
  input  wire logic                       clk_i,
  input  wire logic [mwm_pkg::ProdW-1:0]  dividend_i,
  input  wire logic [mwm_pkg::MagW-1:0]   divisor_i,
  output logic      [mwm_pkg::QuoW-1:0]   quotient_o
);
  import mwm_pkg::*;

  logic [ProdW-1:0] rem [QuoW+1];
  logic [MagW-1:0]  dvs [QuoW+1];
  logic [QuoW-1:0]  quo [QuoW+1];

  assign rem[0] = dividend_i;
  assign dvs[0] = divisor_i;
  assign quo[0] = '0;

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    localparam int Bit = QuoW - 1 - s;

    logic [ProdW-1:0] trial;
    logic             ge;
    logic [ProdW-1:0] rem_d, rem_q;
    logic [MagW-1:0]  dvs_q;
    logic [QuoW-1:0]  quo_d, quo_q;

    // divisor aligned to the quotient bit under test
    assign trial = ProdW'(dvs[s]) << Bit;
    assign ge    = (rem[s] >= trial);
    assign rem_d = ge ? (rem[s] - trial) : rem[s];
    assign quo_d = {quo[s][QuoW-2:0], ge};

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      dvs_q <= dvs[s];
      quo_q <= quo_d;
    end

    assign rem[s+1] = rem_q;
    assign dvs[s+1] = dvs_q;
    assign quo[s+1] = quo_q;
  end

  assign quotient_o = quo[QuoW];

endmodule

`default_nettype wire

>>> design/mecanum_wheel_mixer.sv
// ---------------------------------------------------------------------------
// mecanum_wheel_mixer: mecanum inverse kinematics with proportional limiting
// Turns a body velocity command into four wheel commands and scales all
// wheels down together when the largest one exceeds the wheel limit.
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  -----------------------------------------
//  command   start_i / busy_o       side_speed_i, forward_speed_i, turn_speed_i
//  wheels    valid_o (strobe)       front_left_o, front_right_o, rear_left_o,
//                                   rear_right_o, was_scaled_o
//  limit     cfg_we_i               cfg_wdata_i (wheel limit, 15 bits)
//
// one request is taken every clock cycle; each result passes the stages for
// sums, magnitudes and peak/products, then the one-bit-per-stage divider
// lanes and one output register
// busy_o is tied low: the pipeline never stalls and the receiver cannot stall
// reset clears the valid bits and loads the wheel limit with 7200; data
// registers are not reset
// ---------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // body command request
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [mwm_pkg::InW-1:0] side_speed_i,
  input  wire logic signed [mwm_pkg::InW-1:0] forward_speed_i,
  input  wire logic signed [mwm_pkg::InW-1:0] turn_speed_i,
  // wheel limit register
  input  wire logic                         cfg_we_i,
  input  wire logic [mwm_pkg::LimW-1:0]     cfg_wdata_i,
  // wheel commands
  output logic                              valid_o,
  output logic signed [mwm_pkg::OutW-1:0]   front_left_o,
  output logic signed [mwm_pkg::OutW-1:0]   front_right_o,
  output logic signed [mwm_pkg::OutW-1:0]   rear_left_o,
  output logic signed [mwm_pkg::OutW-1:0]   rear_right_o,
  output logic                              was_scaled_o
);
  import mwm_pkg::*;

  // valid bits: three front stages plus the divider stages
  localparam int VldLen = 3 + QuoW;

  logic                 accept;
  logic [VldLen-1:0]    vld_q;
  logic [LimW-1:0]      limit_q;

  // stage 1: wheel sums
  logic signed [SumW-1:0] s_ext, f_ext, t_ext;
  logic signed [SumW-1:0] sum_d [NumWheels];
  logic signed [SumW-1:0] sum_q [NumWheels];
  logic [LimW-1:0]        lim1_q;

  // stage 2: magnitudes and signs
  wheel_mag_t             mag_d, mag2_q;
  logic [NumWheels-1:0]   neg_d, neg2_q;
  logic [LimW-1:0]        lim2_q;

  // stage 3: peak magnitude and products
  logic [MagW-1:0]        max_a, max_b, peak_d, peak_q;
  logic [ProdW-1:0]       prod_d [NumWheels];
  logic [ProdW-1:0]       prod_q [NumWheels];
  wheel_mag_t             mag3_q;
  logic [NumWheels-1:0]   neg3_q;
  logic [LimW-1:0]        lim3_q;

  // divider stages
  side_t                  side_d;
  side_t                  side_q [QuoW];
  logic [QuoW-1:0]        quo [NumWheels];

  // output stage
  logic signed [OutW-1:0] wheel_d [NumWheels];

  // never stalls, so a request is taken whenever start_i is high
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // limit register: write only while no request is in flight (not enforced)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[VldLen-2:0], accept};
      valid_o <= vld_q[VldLen-1];
    end
  end

  // stage 1: O-layout mixing
  assign s_ext = SumW'(side_speed_i);
  assign f_ext = SumW'(forward_speed_i);
  assign t_ext = SumW'(turn_speed_i);

  assign sum_d[0] = f_ext + s_ext + t_ext;  // front left
  assign sum_d[1] = f_ext - s_ext - t_ext;  // front right
  assign sum_d[2] = f_ext - s_ext + t_ext;  // rear left
  assign sum_d[3] = f_ext + s_ext - t_ext;  // rear right

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumWheels; i++) begin
      sum_q[i] <= sum_d[i];
    end
    lim1_q <= limit_q;
  end

  // stage 2: sign and magnitude, |sum| fits in 17 bits
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      neg_d[i] = sum_q[i][SumW-1];
      mag_d[i] = neg_d[i] ? MagW'(-sum_q[i]) : MagW'(sum_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    mag2_q <= mag_d;
    neg2_q <= neg_d;
    lim2_q <= lim1_q;
  end

  // stage 3: largest magnitude by a two-level compare, and |w| * limit
  assign max_a  = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
  assign max_b  = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
  assign peak_d = (max_a > max_b) ? max_a : max_b;

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      prod_d[i] = ProdW'(mag2_q[i]) * ProdW'(lim2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    peak_q <= peak_d;
    for (int i = 0; i < NumWheels; i++) begin
      prod_q[i] <= prod_d[i];
    end
    mag3_q <= mag2_q;
    neg3_q <= neg2_q;
    lim3_q <= lim2_q;
  end

  // scaling only above the limit; then |w| * limit / peak stays below 2^15
  assign side_d.mag    = mag3_q;
  assign side_d.neg    = neg3_q;
  assign side_d.scaled = (peak_q > MagW'(lim3_q));

  // sideband shifts in step with the divider lanes
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < QuoW; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // one divider lane per wheel, all sharing the peak as divisor
  for (genvar w = 0; w < NumWheels; w++) begin : g_lane
    mwm_div_pipe u_div (
      .clk_i      (clk_i),
      .dividend_i (prod_q[w]),
      .divisor_i  (peak_q),
      .quotient_o (quo[w])
    );
  end

  // output stage: pick scaled or raw magnitude, then restore the sign
  // (truncation toward zero falls out of dividing the magnitude)
  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      logic [OutW-1:0] m;
      m = side_q[QuoW-1].scaled ? OutW'(quo[i]) : side_q[QuoW-1].mag[i][OutW-1:0];
      wheel_d[i] = side_q[QuoW-1].neg[i] ? -signed'(m) : signed'(m);
    end
  end

  always_ff @(posedge clk_i) begin
    front_left_o  <= wheel_d[0];
    front_right_o <= wheel_d[1];
    rear_left_o   <= wheel_d[2];
    rear_right_o  <= wheel_d[3];
    was_scaled_o  <= side_q[QuoW-1].scaled;
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for the mecanum wheel mixer
// Sends body velocity requests (a directed table, then random phases at
// several wheel limits) and checks every wheel result against a local
// inverse kinematics and proportional limiting predictor.
// ---------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mwm_pkg::*;

  // one wheel result, in port order
  typedef struct packed {
    logic signed [OutW-1:0] fl;
    logic signed [OutW-1:0] fr;
    logic signed [OutW-1:0] rl;
    logic signed [OutW-1:0] rr;
    logic                   scaled;
  } wheels_t;

  // a row of the directed table: either a request or a limit write
  typedef enum logic {ROW_CMD, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic signed [InW-1:0]  side;
    logic signed [InW-1:0]  fwd;
    logic signed [InW-1:0]  turn;
    logic [LimW-1:0]        limit;
    bit                     typed;  // want holds a hand-written result
    wheels_t                want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic signed [InW-1:0]  side_speed;
  logic signed [InW-1:0]  forward_speed;
  logic signed [InW-1:0]  turn_speed;
  logic                   cfg_we;
  logic [LimW-1:0]        cfg_wdata;
  logic                   valid;
  logic signed [OutW-1:0] front_left;
  logic signed [OutW-1:0] front_right;
  logic signed [OutW-1:0] rear_left;
  logic signed [OutW-1:0] rear_right;
  logic                   was_scaled;

  // bench copy of the wheel limit register
  logic [LimW-1:0] wheel_limit;
  // wheel results still owed by the block, oldest first
  wheels_t         pending_wheels[$];
  int              mismatches = 0;
  plan_row_t       plan[$];

  mecanum_wheel_mixer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .side_speed_i   (side_speed),
    .forward_speed_i(forward_speed),
    .turn_speed_i   (turn_speed),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .valid_o        (valid),
    .front_left_o   (front_left),
    .front_right_o  (front_right),
    .rear_left_o    (rear_left),
    .rear_right_o   (rear_right),
    .was_scaled_o   (was_scaled)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generous run limit, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // inverse kinematics of an O-layout base, then proportional limiting:
  // all four wheels scale by limit / peak, truncated toward zero, only when
  // the peak magnitude is strictly above the limit
  function automatic wheels_t mix_wheels(logic signed [InW-1:0] side,
                                         logic signed [InW-1:0] fwd,
                                         logic signed [InW-1:0] turn,
                                         logic [LimW-1:0] lim);
    longint  w[4];
    longint  peak;
    longint  lim_v;
    longint  m;
    wheels_t r;
    lim_v = lim;
    w[0] = longint'(fwd) + longint'(side) + longint'(turn);
    w[1] = longint'(fwd) - longint'(side) - longint'(turn);
    w[2] = longint'(fwd) - longint'(side) + longint'(turn);
    w[3] = longint'(fwd) + longint'(side) - longint'(turn);
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      m = (w[i] < 0) ? -w[i] : w[i];
      if (m > peak) peak = m;
    end
    r.scaled = (peak > lim_v);
    // a zero limit squashes any nonzero set to zeros; peak is nonzero here
    if (r.scaled) begin
      for (int i = 0; i < 4; i++) w[i] = (w[i] * lim_v) / peak;
    end
    r.fl = OutW'(w[0]);
    r.fr = OutW'(w[1]);
    r.rl = OutW'(w[2]);
    r.rr = OutW'(w[3]);
    return r;
  endfunction

  function automatic plan_row_t plan_row(row_kind_e kind, int side, int fwd, int turn,
                                         int limit, bit typed,
                                         int fl, int fr, int rl, int rr, bit sc);
    plan_row_t r;
    r.kind        = kind;
    r.side        = InW'(side);
    r.fwd         = InW'(fwd);
    r.turn        = InW'(turn);
    r.limit       = LimW'(limit);
    r.typed       = typed;
    r.want.fl     = OutW'(fl);
    r.want.fr     = OutW'(fr);
    r.want.rl     = OutW'(rl);
    r.want.rr     = OutW'(rr);
    r.want.scaled = sc;
    return r;
  endfunction

  // random speed: extremes now and then, full range for bit coverage,
  // and half the time values small enough that the limit is often not reached
  function automatic logic signed [InW-1:0] rand_speed(logic [LimW-1:0] lim);
    int mode;
    int span;
    mode = $urandom_range(0, 9);
    span = lim / 3 + 1;
    if (mode == 0) begin
      case ($urandom_range(0, 5))
        0:       return -16'sd32768;
        1:       return 16'sd32767;
        2:       return -16'sd32767;
        3:       return 16'sd1;
        4:       return -16'sd1;
        default: return 16'sd0;
      endcase
    end
    if (mode <= 4) return InW'($urandom);
    return InW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic wait_drained();
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  // limit writes only while nothing is in flight
  task automatic set_limit(logic [LimW-1:0] v);
    start <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    wheel_limit = v;
  endtask

  // start stays high across back-to-back requests; it drops for a gap or a limit write
  task automatic send_cmd(logic signed [InW-1:0] side, logic signed [InW-1:0] fwd,
                          logic signed [InW-1:0] turn, int gap, bit typed,
                          wheels_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    side_speed    <= side;
    forward_speed <= fwd;
    turn_speed    <= turn;
    do @(posedge clk); while (busy);
    if (typed) pending_wheels.push_back(want);
    else pending_wheels.push_back(mix_wheels(side, fwd, turn, wheel_limit));
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: every strobe is taken, checked against the oldest request
  always @(posedge clk) begin
    wheels_t want;
    if (rst_n && valid) begin
      if (pending_wheels.size() == 0) begin
        $display("%0t unexpected wheel result: expected none actual %0d %0d %0d %0d %0d",
                 $time, front_left, front_right, rear_left, rear_right, was_scaled);
        mismatches++;
      end else begin
        want = pending_wheels.pop_front();
        check_field("front_left", want.fl, front_left);
        check_field("front_right", want.fr, front_right);
        check_field("rear_left", want.rl, rear_left);
        check_field("rear_right", want.rr, rear_right);
        check_field("was_scaled", want.scaled, was_scaled);
      end
    end
  end

  initial begin
    logic [LimW-1:0] lim;
    bit              burst;
    int              gap;

    rst_n         <= 1'b0;
    start         <= 1'b0;
    side_speed    <= '0;
    forward_speed <= '0;
    turn_speed    <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    wheel_limit   = LimitReset;

    // directed table                       side    fwd    turn  limit typed  fl fr rl rr sc
    // reset limit of 7200: zero command, peak equal to limit, one above
    plan.push_back(plan_row(ROW_CMD,         0,      0,      0, 0, 1, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         0,   7200,      0, 0, 1,
                            7200, 7200, 7200, 7200, 0));
    plan.push_back(plan_row(ROW_CMD,         0,   7201,      0, 0, 1,
                            7200, 7200, 7200, 7200, 1));
    plan.push_back(plan_row(ROW_CMD,     32767,  32767,  32767, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,    -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         1,      0,      0, 0, 1, 1, -1, -1, 1, 0));
    plan.push_back(plan_row(ROW_CMD,         0,      0,     -1, 0, 1, -1, 1, -1, 1, 0));
    plan.push_back(plan_row(ROW_CMD,    -32768,  32767, -32768, 0, 0, 0, 0, 0, 0, 0));
    // zero limit: nonzero sets collapse to zero, the zero set passes
    plan.push_back(plan_row(ROW_LIMIT,       0,      0,      0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         0,      0,      0, 0, 1, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         5,      0,      0, 0, 1, 0, 0, 0, 0, 1));
    plan.push_back(plan_row(ROW_CMD,    -32768, -32768, -32768, 0, 1, 0, 0, 0, 0, 1));
    // limit of one
    plan.push_back(plan_row(ROW_LIMIT,       0,      0,      0, 1, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         3,     -2,      7, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         0,      1,      0, 0, 1, 1, 1, 1, 1, 0));
    plan.push_back(plan_row(ROW_CMD,         0,     -2,      0, 0, 1, -1, -1, -1, -1, 1));
    // largest limit, most negative input still gets scaled
    plan.push_back(plan_row(ROW_LIMIT,       0,      0,      0, 32767, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,     32767,  32767,  32767, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,         0, -32767,      0, 0, 1,
                            -32767, -32767, -32767, -32767, 0));
    plan.push_back(plan_row(ROW_CMD,    -32768,      0,      0, 0, 1,
                            -32767, 32767, 32767, -32767, 1));
    plan.push_back(plan_row(ROW_CMD,     12345, -23456,   3210, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_LIMIT,       0,      0,      0, 7200, 0, 0, 0, 0, 0, 0));
    plan.push_back(plan_row(ROW_CMD,      -100,   5000,  -3000, 0, 0, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) set_limit(plan[i].limit);
      else send_cmd(plan[i].side, plan[i].fwd, plan[i].turn, $urandom_range(0, 19),
                    plan[i].typed, plan[i].want);
    end

    // random phases: each one drains the pipe and sets a new limit,
    // so the sender also pauses until every result is back
    for (int p = 0; p < 10; p++) begin
      case (p)
        3:       lim = '0;
        6:       lim = LimW'(32767);
        8:       lim = LimW'(1);
        default: lim = (p % 2) ? LimW'($urandom_range(1, 255)) : LimW'($urandom);
      endcase
      set_limit(lim);
      // some phases run back to back with no idle cycles at all
      burst = (p % 3 == 1);
      for (int n = 0; n < 40; n++) begin
        gap = burst ? 0 : $urandom_range(0, 19);
        send_cmd(rand_speed(wheel_limit), rand_speed(wheel_limit),
                 rand_speed(wheel_limit), gap, 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait_drained();
    // pipeline depth plus margin, to catch any stray strobe
    repeat (25) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
